FILE: rtl/sbba_pkg.sv
// ----------------------------------------------------------------------------
// sbba_pkg: shared types and constants for the segmented block allocator
// Slot count, segment geometry, opcodes, status codes and sequencer states.
// ----------------------------------------------------------------------------
package sbba_pkg;

   localparam int MaxSegments      = 8;
   localparam int SegBlocksMax     = 256;
   localparam int WordsPerSeg      = (SegBlocksMax + 31) / 32;
   localparam int SlotW            = $clog2(MaxSegments);
   localparam int WordW            = $clog2(WordsPerSeg);
   localparam int IdxW             = $clog2(SegBlocksMax);
   localparam int LenW             = IdxW + 1;
   localparam int CntW             = $clog2(MaxSegments + 1);
   localparam int PoolW            = 12;
   localparam int MemDepth         = MaxSegments * WordsPerSeg;
   localparam int MemAw            = SlotW + WordW;

   localparam logic [1:0] OpAlloc     = 2'd0;
   localparam logic [1:0] OpFree      = 2'd1;
   localparam logic [1:0] OpFreeAll   = 2'd2;
   localparam logic [1:0] OpFreeEmpty = 2'd3;

   localparam logic [1:0] StOk      = 2'd0;
   localparam logic [1:0] StNoMem   = 2'd1;
   localparam logic [1:0] StInvalid = 2'd2;

   localparam logic [0:0] RegSegBlocks = 1'd0;
   localparam logic [0:0] RegMaxSegs   = 1'd1;

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_PICK   = 9'b000000010,
      S_CLEAR  = 9'b000000100,
      S_RDWORD = 9'b000001000,
      S_SCAN   = 9'b000010000,
      S_FRD    = 9'b000100000,
      S_FCHK   = 9'b001000000,
      S_EMPTY  = 9'b010000000,
      S_DONE   = 9'b100000000
   } state_type;

endpackage

FILE: rtl/sbba_ram.sv
// ----------------------------------------------------------------------------
// sbba_ram: generic single-port RAM
// One address per cycle: always read, written when we is high; read data registered.
// ----------------------------------------------------------------------------
module sbba_ram #(
   parameter int Width = 32,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wdata,
   output logic [Width-1:0]         rdata
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rdata_ff;

   // write or read one word
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/segmented_bitmap_block_allocator.sv
// ----------------------------------------------------------------------------
// segmented_bitmap_block_allocator: fixed-size block allocator
// Hands out blocks from up to eight segments, each tracked by a bitmap in one shared RAM.
// ----------------------------------------------------------------------------
// One command at a time: busy rises the cycle after start and the result beat
// appears on rsp_valid for one cycle, which the receiver must take. Timing is
// set by the single bitmap RAM port and the slot-by-slot sequencer: allocate
// in an existing segment reads and scans one 32-bit word at a time until a
// clear bit is found; opening a segment first zeroes each of its words.
// Free reads the word and clears the bit, free-all clears the tables, and
// free-empty visits one slot per cycle. Result counts: free_blocks and total_blocks.
// ----------------------------------------------------------------------------
module segmented_bitmap_block_allocator import sbba_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_op,
   input  logic [2:0]         req_seg_slot,
   input  logic [7:0]         req_block_index,
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic [2:0]         rsp_out_slot,
   output logic [7:0]         rsp_out_index,
   output logic [11:0]        rsp_free_blocks,
   output logic [11:0]        rsp_total_blocks,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   state_type state_ff, state_in;

   // configuration
   logic [8:0] seg_blocks_ff;
   logic [3:0] max_segs_ff;
   logic       csr_wr;
   logic [0:0] csr_reg;

   // command latch
   logic [1:0]       op_ff;
   logic [SlotW-1:0] fslot_ff;
   logic [IdxW-1:0]  fidx_ff;

   // segment tables
   logic [MaxSegments-1:0] live_ff;
   logic [LenW-1:0]        fcnt_ff [MaxSegments];
   logic [LenW-1:0]        len_ff  [MaxSegments];
   logic [SlotW-1:0]       rank_ff [MaxSegments];
   logic [CntW-1:0]        seg_cnt_ff;
   logic [PoolW-1:0]       pool_ff;

   // sequencer working registers
   logic [SlotW-1:0] slot_ff;
   logic [WordW-1:0] word_ff;
   logic [SlotW-1:0] scan_ff;

   // result registers
   logic             rv_ff;
   logic [1:0]       rst_ff;
   logic [2:0]       rslot_ff;
   logic [7:0]       ridx_ff;

   // RAM port
   logic             ram_we;
   logic [MemAw-1:0] ram_addr;
   logic [31:0]      ram_wdata, ram_rdata;

   sbba_ram #(.Width(32), .Depth(MemDepth)) u_ram (
      .clock(clock), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
   );

   // effective size and limit
   logic [LenW-1:0]  eff_size;
   logic [CntW-1:0]  eff_limit;
   always_comb begin
      if (seg_blocks_ff == '0) eff_size = LenW'(1);
      else if (seg_blocks_ff > 9'(SegBlocksMax)) eff_size = LenW'(SegBlocksMax);
      else eff_size = LenW'(seg_blocks_ff);
      if (max_segs_ff == '0 || max_segs_ff > 4'(MaxSegments)) eff_limit = CntW'(MaxSegments);
      else eff_limit = CntW'(max_segs_ff);
   end

   // newest live segment with room, and lowest free slot
   logic             best_found, free_found;
   logic [SlotW-1:0] best_slot, free_slot;
   always_comb begin
      best_found = 1'b0;
      best_slot  = '0;
      free_found = 1'b0;
      free_slot  = '0;
      for (int s = 0; s < MaxSegments; s++) begin
         if (live_ff[s] && fcnt_ff[s] != '0 &&
             (!best_found || rank_ff[s] < rank_ff[best_slot])) begin
            best_found = 1'b1;
            best_slot  = SlotW'(s);
         end
         if (!live_ff[s] && !free_found) begin
            free_found = 1'b1;
            free_slot  = SlotW'(s);
         end
      end
   end

   // lowest clear bit of the read word, limited to the segment length
   logic [LenW-1:0] word_base;
   logic [31:0]     word_mask;
   logic            bit_found;
   logic [4:0]      bit_pos;
   logic [LenW-1:0] hit_idx;
   always_comb begin
      word_base = LenW'({word_ff, 5'd0});
      bit_found = 1'b0;
      bit_pos   = '0;
      for (int b = 31; b >= 0; b--) begin
         word_mask[b] = (word_base + LenW'(b)) < len_ff[slot_ff];
         if (!ram_rdata[b] && word_mask[b]) begin
            bit_found = 1'b1;
            bit_pos   = 5'(b);
         end
      end
      hit_idx = word_base + LenW'(bit_pos);
   end

   logic fbit;
   assign fbit = ram_rdata[fidx_ff[4:0]];
   logic last_word;
   assign last_word = (word_base + LenW'(32)) >= len_ff[slot_ff];

   assign csr_wr  = psel && penable && pwrite;
   assign csr_reg = paddr[2:2];
   assign pready  = 1'b1;
   assign prdata  = (csr_reg == RegSegBlocks) ? {23'd0, seg_blocks_ff} : {28'd0, max_segs_ff};

   // RAM control
   always_comb begin
      ram_we    = 1'b0;
      ram_wdata = '0;
      ram_addr  = {slot_ff, word_ff};
      unique case (state_ff)
         S_CLEAR: ram_we = 1'b1;
         S_SCAN: begin
            ram_we    = bit_found;
            ram_wdata = ram_rdata | (32'd1 << bit_pos);
         end
         S_FRD: ram_addr = {fslot_ff, fidx_ff[IdxW-1:5]};
         S_FCHK: begin
            ram_addr  = {fslot_ff, fidx_ff[IdxW-1:5]};
            ram_we    = live_ff[fslot_ff] && LenW'(fidx_ff) < len_ff[fslot_ff] && fbit;
            ram_wdata = ram_rdata & ~(32'd1 << fidx_ff[4:0]);
         end
         default: ;
      endcase
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (start) begin
            unique case (req_op)
               OpAlloc:     state_in = S_PICK;
               OpFree:      state_in = S_FRD;
               OpFreeAll:   state_in = S_DONE;
               OpFreeEmpty: state_in = S_EMPTY;
            endcase
         end
         S_PICK: begin
            if (best_found) state_in = S_RDWORD;
            else if (seg_cnt_ff >= eff_limit || !free_found) state_in = S_DONE;
            else state_in = S_CLEAR;
         end
         S_CLEAR:  if (word_ff == WordW'(WordsPerSeg - 1)) state_in = S_RDWORD;
         S_RDWORD: state_in = S_SCAN;
         S_SCAN:   state_in = (bit_found || last_word) ? S_DONE : S_RDWORD;
         S_FRD:    state_in = S_FCHK;
         S_FCHK:   state_in = S_DONE;
         S_EMPTY:  if (scan_ff == SlotW'(MaxSegments - 1)) state_in = S_DONE;
         S_DONE:   state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         seg_blocks_ff <= 9'd256;
         max_segs_ff   <= '0;
         live_ff       <= '0;
         seg_cnt_ff    <= '0;
         pool_ff       <= '0;
         rv_ff         <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= 1'b0;
         if (csr_wr) begin
            if (csr_reg == RegSegBlocks) seg_blocks_ff <= pwdata[8:0];
            else max_segs_ff <= pwdata[3:0];
         end
         unique case (state_ff)
            S_IDLE: if (start) begin
               op_ff    <= req_op;
               fslot_ff <= req_seg_slot;
               fidx_ff  <= req_block_index;
               rst_ff   <= StOk;
               rslot_ff <= '0;
               ridx_ff  <= '0;
               word_ff  <= '0;
               scan_ff  <= '0;
               if (req_op == OpFreeAll) begin
                  live_ff    <= '0;
                  seg_cnt_ff <= '0;
                  pool_ff    <= '0;
               end
            end
            S_PICK: begin
               if (best_found) slot_ff <= best_slot;
               else if (seg_cnt_ff >= eff_limit || !free_found) rst_ff <= StNoMem;
               else begin
                  // open a new segment as the newest
                  slot_ff <= free_slot;
                  for (int s = 0; s < MaxSegments; s++)
                     if (live_ff[s]) rank_ff[s] <= rank_ff[s] + 1'b1;
                  live_ff[free_slot] <= 1'b1;
                  len_ff[free_slot]  <= eff_size;
                  fcnt_ff[free_slot] <= eff_size;
                  rank_ff[free_slot] <= '0;
                  seg_cnt_ff         <= seg_cnt_ff + 1'b1;
                  pool_ff            <= pool_ff + PoolW'(eff_size);
               end
            end
            S_CLEAR: word_ff <= (word_ff == WordW'(WordsPerSeg - 1)) ? '0 : word_ff + 1'b1;
            S_SCAN: begin
               if (bit_found) begin
                  fcnt_ff[slot_ff] <= fcnt_ff[slot_ff] - 1'b1;
                  pool_ff          <= pool_ff - 1'b1;
                  rslot_ff         <= 3'(slot_ff);
                  ridx_ff          <= 8'(hit_idx);
               end else if (last_word) rst_ff <= StNoMem;
               else word_ff <= word_ff + 1'b1;
            end
            S_FCHK: begin
               if (live_ff[fslot_ff] && LenW'(fidx_ff) < len_ff[fslot_ff] && fbit) begin
                  fcnt_ff[fslot_ff] <= fcnt_ff[fslot_ff] + 1'b1;
                  pool_ff           <= pool_ff + 1'b1;
               end else rst_ff <= StInvalid;
            end
            S_EMPTY: begin
               // drop one wholly free slot and close the rank gap
               if (live_ff[scan_ff] && fcnt_ff[scan_ff] == len_ff[scan_ff]) begin
                  live_ff[scan_ff] <= 1'b0;
                  seg_cnt_ff       <= seg_cnt_ff - 1'b1;
                  pool_ff          <= pool_ff - PoolW'(len_ff[scan_ff]);
                  for (int t = 0; t < MaxSegments; t++)
                     if (live_ff[t] && rank_ff[t] > rank_ff[scan_ff])
                        rank_ff[t] <= rank_ff[t] - 1'b1;
               end
               scan_ff <= scan_ff + 1'b1;
            end
            S_DONE: rv_ff <= 1'b1;
            default: ;
         endcase
      end
   end

   // total is a narrow multiply of count by size
   logic [PoolW+CntW-1:0] total_full;
   assign total_full = PoolW'(seg_cnt_ff) * (PoolW+CntW)'(eff_size);

   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = rv_ff;
   assign rsp_status       = rst_ff;
   assign rsp_out_slot     = rslot_ff;
   assign rsp_out_index    = ridx_ff;
   assign rsp_free_blocks  = pool_ff;
   assign rsp_total_blocks = total_full[PoolW-1:0];

   // checks
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      seg_cnt_ff <= CntW'(MaxSegments)) else $error("segment count over slots");
   a_cnt_live: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> CntW'($countones(live_ff)) == seg_cnt_ff)
      else $error("segment count disagrees with live slots");
   a_rsp_after_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == S_DONE)) else $error("stray result beat");
   a_handle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && op_ff != OpAlloc |-> rsp_out_slot == '0 && rsp_out_index == '0)
      else $error("block handle on a non-allocate result");

endmodule

FILE: verif/sbba_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbba_checker: result predictor and scoreboard for the block allocator
// Watches the command, result and register ports, keeps its own copy of the
// segment bitmaps and counters, and compares every result beat with the
// oldest predicted one.
// ----------------------------------------------------------------------------
module sbba_checker import sbba_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [1:0]  req_op,
   input  logic [2:0]  req_seg_slot,
   input  logic [7:0]  req_block_index,
   input  logic        rsp_valid,
   input  logic [1:0]  rsp_status,
   input  logic [2:0]  rsp_out_slot,
   input  logic [7:0]  rsp_out_index,
   input  logic [11:0] rsp_free_blocks,
   input  logic [11:0] rsp_total_blocks,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic        pready,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output int          fail_count,
   output int          pending
);

   localparam logic [2:0] AddrSegBlocks = 3'(4 * RegSegBlocks);
   localparam logic [2:0] AddrMaxSegs   = 3'(4 * RegMaxSegs);

   typedef struct {
      logic [1:0]  status;
      logic [2:0]  slot;
      logic [7:0]  index;
      logic [11:0] free_blocks;
      logic [11:0] total_blocks;
   } alloc_result_type;

   alloc_result_type result_q[$];

   // Shadow allocator state
   logic [SegBlocksMax-1:0] map [MaxSegments];
   logic                    live [MaxSegments];
   int                      seg_free [MaxSegments];
   int                      seg_len [MaxSegments];
   int                      rank [MaxSegments];
   int                      seg_cnt;
   int                      pool_free;
   logic [8:0]              size_reg;
   logic [3:0]              limit_reg;

   function automatic int cur_size();
      if (size_reg == 0) return 1;
      if (size_reg > SegBlocksMax) return SegBlocksMax;
      return size_reg;
   endfunction

   function automatic int cur_limit();
      if (limit_reg == 0 || limit_reg > MaxSegments) return MaxSegments;
      return limit_reg;
   endfunction

   task automatic clear_shadow();
      for (int s = 0; s < MaxSegments; s++) begin
         map[s] = '0;
         live[s] = 1'b0;
         seg_free[s] = 0;
         seg_len[s] = 0;
         rank[s] = 0;
      end
      seg_cnt = 0;
      pool_free = 0;
      size_reg = 9'd256;
      limit_reg = 4'd0;
   endtask

   // Allocate: newest segment with room, else open one in the lowest dead slot
   task automatic run_alloc(ref alloc_result_type r);
      int best;
      int s;
      best = -1;
      for (int k = 0; k < MaxSegments; k++)
         if (live[k] && seg_free[k] > 0 && (best < 0 || rank[k] < rank[best])) best = k;
      if (best < 0) begin
         if (seg_cnt >= cur_limit()) begin
            r.status = StNoMem;
            return;
         end
         s = 0;
         while (s < MaxSegments && live[s]) s++;
         if (s >= MaxSegments) begin
            r.status = StNoMem;
            return;
         end
         for (int k = 0; k < MaxSegments; k++) if (live[k]) rank[k]++;
         map[s] = '0;
         live[s] = 1'b1;
         seg_len[s] = cur_size();
         seg_free[s] = cur_size();
         rank[s] = 0;
         seg_cnt++;
         pool_free += cur_size();
         best = s;
      end
      for (int i = 0; i < seg_len[best]; i++) begin
         if (!map[best][i]) begin
            map[best][i] = 1'b1;
            seg_free[best]--;
            pool_free--;
            r.slot = 3'(best);
            r.index = 8'(i);
            return;
         end
      end
      r.status = StNoMem;
   endtask

   task automatic predict(input logic [1:0] op, input logic [2:0] slot,
                          input logic [7:0] idx);
      alloc_result_type r;
      r = '{StOk, 3'd0, 8'd0, 12'd0, 12'd0};
      case (op)
         OpAlloc: begin
            run_alloc(r);
         end
         OpFree: begin
            if (!live[slot] || idx >= seg_len[slot] || !map[slot][idx]) begin
               r.status = StInvalid;
            end else begin
               map[slot][idx] = 1'b0;
               seg_free[slot]++;
               pool_free++;
            end
         end
         OpFreeAll: begin
            for (int k = 0; k < MaxSegments; k++) live[k] = 1'b0;
            seg_cnt = 0;
            pool_free = 0;
         end
         default: begin
            // drop wholly free segments, close the age gaps they leave
            for (int k = 0; k < MaxSegments; k++) begin
               if (live[k] && seg_free[k] == seg_len[k]) begin
                  live[k] = 1'b0;
                  seg_cnt--;
                  pool_free -= seg_len[k];
                  for (int t = 0; t < MaxSegments; t++)
                     if (live[t] && rank[t] > rank[k]) rank[t]--;
               end
            end
         end
      endcase
      r.free_blocks = 12'(pool_free);
      r.total_blocks = 12'(seg_cnt * cur_size());
      result_q.push_back(r);
   endtask

   task automatic check_field(input string name, input int exp_v, input int act_v);
      if (exp_v != act_v) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      end
   endtask

   initial begin
      fail_count = 0;
      clear_shadow();
   end

   assign pending = result_q.size();

   always @(posedge clock) begin
      alloc_result_type e;
      if (reset) begin
         clear_shadow();
         result_q.delete();
      end else begin
         // compare the result beat before taking any new command beat
         if (rsp_valid) begin
            if (result_q.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result beat, status %0d", $time, rsp_status);
            end else begin
               e = result_q.pop_front();
               check_field("status", e.status, rsp_status);
               check_field("out_slot", e.slot, rsp_out_slot);
               check_field("out_index", e.index, rsp_out_index);
               check_field("free_blocks", e.free_blocks, rsp_free_blocks);
               check_field("total_blocks", e.total_blocks, rsp_total_blocks);
            end
         end
         if (start && !busy) predict(req_op, req_seg_slot, req_block_index);
         if (psel && penable && pwrite && pready) begin
            if (paddr == AddrSegBlocks) size_reg = pwdata[8:0];
            else if (paddr == AddrMaxSegs) limit_reg = pwdata[3:0];
         end
      end
   end

endmodule

FILE: verif/segmented_bitmap_block_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segmented_bitmap_block_allocator_tb: stimulus and verdict for the allocator
// Runs directed corner commands, then random command mixes under several
// segment size and segment limit settings, with random gaps between beats.
// ----------------------------------------------------------------------------
module segmented_bitmap_block_allocator_tb import sbba_pkg::*;;

   localparam int CycleLimit = 300000;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_op;
   logic [2:0]  req_seg_slot;
   logic [7:0]  req_block_index;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [2:0]  rsp_out_slot;
   logic [7:0]  rsp_out_index;
   logic [11:0] rsp_free_blocks;
   logic [11:0] rsp_total_blocks;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;
   int          fail_count;
   int          pending;
   int          cycles;

   typedef struct {
      logic [2:0] slot;
      logic [7:0] index;
   } handle_type;

   handle_type held_q[$];
   logic [1:0] issued_q[$];

   segmented_bitmap_block_allocator uut (.*);

   sbba_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // run guard
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CycleLimit) begin
         $display("Verification failed");
         $finish;
      end
   end

   // collect handles of granted blocks for later frees
   always @(posedge clock) begin
      logic [1:0] op;
      if (!reset && rsp_valid && issued_q.size() > 0) begin
         op = issued_q.pop_front();
         if (op == OpAlloc && rsp_status == StOk)
            held_q.push_back('{rsp_out_slot, rsp_out_index});
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // drive one command beat; start stays high after acceptance
   task automatic send(input logic [1:0] op, input logic [2:0] slot, input logic [7:0] idx);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_op <= op;
      req_seg_slot <= slot;
      req_block_index <= idx;
      do @(posedge clock); while (busy);
      issued_q.push_back(op);
      if (op == OpFreeAll) held_q.delete();
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
      drain();
      psel <= 1'b1;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(input int seg_blocks, input int max_segs);
      write_reg(3'(4 * RegSegBlocks), 32'(seg_blocks));
      write_reg(3'(4 * RegMaxSegs), 32'(max_segs));
   endtask

   // random mix: mostly allocates and frees of held blocks
   task automatic random_phase(input int count);
      int r;
      int k;
      handle_type h;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if (r < 48) begin
            send(OpAlloc, 3'($urandom), 8'($urandom));
         end else if (r < 78 && held_q.size() > 0) begin
            k = $urandom_range(0, held_q.size() - 1);
            h = held_q[k];
            held_q.delete(k);
            send(OpFree, h.slot, h.index);
         end else if (r < 88) begin
            send(OpFree, 3'($urandom), 8'($urandom));
         end else if (r < 92) begin
            send(OpFreeAll, 3'($urandom), 8'($urandom));
         end else begin
            send(OpFreeEmpty, 3'($urandom), 8'($urandom));
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_op = OpAlloc;
      req_seg_slot = '0;
      req_block_index = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: corners at reset settings, then tiny segments, then oversized settings
      send(OpFree, 3'd7, 8'd255);
      send(OpFreeEmpty, 3'd0, 8'd0);
      send(OpAlloc, 3'd0, 8'd0);
      send(OpAlloc, 3'd0, 8'd0);
      send(OpFree, 3'd0, 8'd255);
      send(OpFree, 3'd0, 8'd1);
      send(OpFree, 3'd0, 8'd1);
      send(OpFreeEmpty, 3'd0, 8'd0);
      send(OpFree, 3'd0, 8'd0);
      send(OpFreeEmpty, 3'd0, 8'd0);
      send(OpFreeAll, 3'd7, 8'd255);
      set_config(0, 2);
      send(OpAlloc, 3'd0, 8'd0);
      send(OpAlloc, 3'd0, 8'd0);
      send(OpAlloc, 3'd0, 8'd0);
      send(OpFree, 3'd0, 8'd0);
      send(OpFree, 3'd1, 8'd1);
      send(OpFreeEmpty, 3'd0, 8'd0);
      send(OpAlloc, 3'd0, 8'd0);
      set_config(511, 15);
      send(OpAlloc, 3'd0, 8'd0);
      send(OpFreeAll, 3'd0, 8'd0);

      // random phases over a spread of settings
      set_config(1, 8);
      random_phase(110);
      set_config(5, 3);
      random_phase(120);
      set_config(33, 0);
      random_phase(120);
      set_config(256, 1);
      random_phase(80);
      set_config(3, 8);
      random_phase(130);
      set_config(64, 15);
      random_phase(110);
      set_config(2, 0);
      random_phase(40);

      drain();
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
